FILE: design/fasmd_pkg.sv
// Package for the truncating float add/sub/mul/div unit.
// Holds the format constants, operation and status codes.
`timescale 1ns / 1ps
`default_nettype none
package fasmd_pkg;
   localparam int MantBitsDefault = 24;
   localparam int ExpBitsDefault  = 8;

   typedef enum logic [1:0] {
      KIND_ADD = 2'd0,
      KIND_SUB = 2'd1,
      KIND_MUL = 2'd2,
      KIND_DIV = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_DIVZERO   = 2'd3
   } status_type;
endpackage
`default_nettype wire

FILE: design/fasmd_cell.sv
// One cell of the operation chain: a restoring divide step and a
// shift-add multiply step on the word handed in by the previous cell.
// Depends on fasmd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fasmd_cell
   import fasmd_pkg::*;
#(
   parameter int MANT_BITS = MantBitsDefault,
   parameter int EXP_BITS  = ExpBitsDefault,
   parameter int STEP      = 0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   valid_in,
   input  wire logic [1:0]             kind_in,
   input  wire logic                   neg_in,
   input  wire logic signed [EXP_BITS+2:0] ex_in,
   input  wire logic [MANT_BITS-1:0]   ma_in,
   input  wire logic [MANT_BITS-1:0]   mb_in,
   input  wire logic [MANT_BITS:0]     rem_in,
   input  wire logic [2*MANT_BITS-1:0] acc_in,
   input  wire logic [2:0]             flag_in,
   output logic                        valid_out,
   output logic [1:0]                  kind_out,
   output logic                        neg_out,
   output logic signed [EXP_BITS+2:0]  ex_out,
   output logic [MANT_BITS-1:0]        ma_out,
   output logic [MANT_BITS-1:0]        mb_out,
   output logic [MANT_BITS:0]          rem_out,
   output logic [2*MANT_BITS-1:0]      acc_out,
   output logic [2:0]                  flag_out
);
   localparam int BitIdx = 2*MANT_BITS - 1 - STEP;

   logic                      valid_ff;
   logic [1:0]                kind_ff;
   logic                      neg_ff;
   logic signed [EXP_BITS+2:0] ex_ff;
   logic [MANT_BITS-1:0]      ma_ff, mb_ff;
   logic [MANT_BITS:0]        rem_ff, rem_in_c;
   logic [2*MANT_BITS-1:0]    acc_ff, acc_in_c;
   logic [2:0]                flag_ff;
   logic [MANT_BITS+1:0]      shifted, diff;
   logic                      bit_c;

   always_comb begin
      rem_in_c = rem_in;
      acc_in_c = acc_in;
      bit_c = 1'b0;
      if (BitIdx >= MANT_BITS)
         bit_c = ma_in[(BitIdx >= MANT_BITS) ? BitIdx - MANT_BITS : 0];
      shifted = {rem_in, bit_c};
      diff = shifted - {2'b00, mb_in};
      if (kind_in == KIND_DIV) begin
         if (!diff[MANT_BITS+1]) begin
            rem_in_c = diff[MANT_BITS:0];
            acc_in_c = {acc_in[2*MANT_BITS-2:0], 1'b1};
         end else begin
            rem_in_c = shifted[MANT_BITS:0];
            acc_in_c = {acc_in[2*MANT_BITS-2:0], 1'b0};
         end
      end else if (kind_in == KIND_MUL && STEP < MANT_BITS) begin
         if (mb_in[(STEP < MANT_BITS) ? STEP : 0])
            acc_in_c = acc_in +
               ({{MANT_BITS{1'b0}}, ma_in} << ((STEP < MANT_BITS) ? STEP : 0));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      kind_ff <= kind_in;
      neg_ff  <= neg_in;
      ex_ff   <= ex_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      rem_ff  <= rem_in_c;
      acc_ff  <= acc_in_c;
      flag_ff <= flag_in;
   end

   assign valid_out = valid_ff;
   assign kind_out  = kind_ff;
   assign neg_out   = neg_ff;
   assign ex_out    = ex_ff;
   assign ma_out    = ma_ff;
   assign mb_out    = mb_ff;
   assign rem_out   = rem_ff;
   assign acc_out   = acc_ff;
   assign flag_out  = flag_ff;
endmodule
`default_nettype wire

FILE: design/float_add_sub_mul_div_unit_top.sv
// Truncating float add/sub/mul/div unit, top level.
// Pipeline of stage 0, stage 1, the cell chain and an output register; one word accepted every cycle;
// busy is never raised. Reset clears the valid bits of the cell chain.
// Depends on fasmd_pkg and fasmd_cell.
`timescale 1ns / 1ps
`default_nettype none
module float_add_sub_mul_div_unit_top
   import fasmd_pkg::*;
#(
   parameter int MANT_BITS = MantBitsDefault,
   parameter int EXP_BITS  = ExpBitsDefault
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [1:0]                  req_kind,
   input  wire logic [EXP_BITS+MANT_BITS:0] req_operand_a,
   input  wire logic [EXP_BITS+MANT_BITS:0] req_operand_b,
   output logic                             rsp_valid,
   output logic [EXP_BITS+MANT_BITS:0]      rsp_result_value,
   output logic [1:0]                       rsp_status
);
   localparam int N  = 2*MANT_BITS;
   localparam int EW = EXP_BITS + 3;
   localparam int SW = $clog2(MANT_BITS + 1);
   localparam logic signed [EW-1:0] Bias = EW'((1 << (EXP_BITS-1)) - 1);
   localparam logic signed [EW-1:0] EMax = EW'((1 << EXP_BITS) - 1);
   // flag bit 0: zero result, bit 1: divide by zero

   function automatic logic [SW-1:0] lzc(input logic [MANT_BITS-1:0] m);
      logic [SW-1:0] n;
      logic          f;
      n = '0; f = 1'b0;
      for (int i = MANT_BITS-1; i >= 0; i--) begin
         if (!f && m[i]) f = 1'b1;
         else if (!f) n = n + 1'b1;
      end
      return n;
   endfunction

   // stage 0: unpack and normalize operands
   logic s0_valid_ff;
   logic [1:0] s0_kind_ff;
   logic s0_na_ff, s0_nb_ff;
   logic signed [EW-1:0] s0_ea_ff, s0_eb_ff;
   logic [MANT_BITS-1:0] s0_ma_ff, s0_mb_ff;
   logic [SW-1:0] la, lb;
   logic [MANT_BITS-1:0] raw_a, raw_b;

   assign raw_a = req_operand_a[MANT_BITS-1:0];
   assign raw_b = req_operand_b[MANT_BITS-1:0];
   assign la = lzc(raw_a);
   assign lb = lzc(raw_b);
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) s0_valid_ff <= 1'b0;
      else       s0_valid_ff <= start;
      s0_kind_ff <= req_kind;
      s0_na_ff <= req_operand_a[EXP_BITS+MANT_BITS];
      s0_nb_ff <= req_operand_b[EXP_BITS+MANT_BITS] ^ (req_kind == KIND_SUB);
      s0_ea_ff <= EW'({1'b0, req_operand_a[EXP_BITS+MANT_BITS-1:MANT_BITS]})
                  - EW'(la);
      s0_eb_ff <= EW'({1'b0, req_operand_b[EXP_BITS+MANT_BITS-1:MANT_BITS]})
                  - EW'(lb);
      s0_ma_ff <= raw_a << la;
      s0_mb_ff <= raw_b << lb;
   end

   // stage 1: add/sub alignment and sum; mul/div exponent setup
   logic s1_valid_ff;
   logic [1:0] s1_kind_ff;
   logic s1_neg_ff;
   logic signed [EW-1:0] s1_ex_ff;
   logic [MANT_BITS:0] s1_sum_ff;
   logic [MANT_BITS-1:0] s1_ma_ff, s1_mb_ff;
   logic [2:0] s1_flag_ff;
   logic a_big;
   logic [EW-1:0] dexp;
   logic [MANT_BITS-1:0] xm, ym, ys;
   logic signed [EW-1:0] xe;
   logic xn, yn;
   logic [MANT_BITS:0] sum_c;
   logic signed [EW-1:0] ex_c;
   logic neg_c;
   logic [2:0] flag_c;
   logic za, zb;

   always_comb begin
      za = (s0_ma_ff == '0);
      zb = (s0_mb_ff == '0);
      a_big = (s0_ea_ff > s0_eb_ff) || (s0_ea_ff == s0_eb_ff && s0_ma_ff >= s0_mb_ff);
      xm = a_big ? s0_ma_ff : s0_mb_ff;
      ym = a_big ? s0_mb_ff : s0_ma_ff;
      xe = a_big ? s0_ea_ff : s0_eb_ff;
      xn = a_big ? s0_na_ff : s0_nb_ff;
      yn = a_big ? s0_nb_ff : s0_na_ff;
      dexp = a_big ? EW'(s0_ea_ff - s0_eb_ff) : EW'(s0_eb_ff - s0_ea_ff);
      ys = (dexp >= EW'(MANT_BITS)) ? '0 : (ym >> dexp);
      flag_c = 3'b000;
      neg_c = xn;
      ex_c = xe;
      sum_c = {1'b0, xm};
      if (s0_kind_ff == KIND_ADD || s0_kind_ff == KIND_SUB) begin
         if (za) begin
            sum_c = {1'b0, s0_mb_ff}; ex_c = s0_eb_ff; neg_c = s0_nb_ff;
            flag_c[0] = zb;
         end else if (zb) begin
            sum_c = {1'b0, s0_ma_ff}; ex_c = s0_ea_ff; neg_c = s0_na_ff;
         end else if (xn == yn) begin
            sum_c = {1'b0, xm} + {1'b0, ys};
         end else begin
            sum_c = {1'b0, xm} - {1'b0, ys};
            flag_c[0] = (sum_c == '0);
         end
      end else begin
         neg_c = s0_na_ff ^ s0_nb_ff;
         if (s0_kind_ff == KIND_MUL) begin
            ex_c = s0_ea_ff + s0_eb_ff - Bias;
            flag_c[0] = za || zb;
         end else begin
            ex_c = s0_ea_ff - s0_eb_ff + Bias;
            flag_c[1] = zb;
            flag_c[0] = za;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s0_valid_ff;
      s1_kind_ff <= s0_kind_ff;
      s1_neg_ff  <= neg_c;
      s1_ex_ff   <= ex_c;
      s1_sum_ff  <= sum_c;
      s1_ma_ff   <= s0_ma_ff;
      s1_mb_ff   <= s0_mb_ff;
      s1_flag_ff <= flag_c;
   end

   // cell chain: one divide quotient bit per cell / one multiply partial product per cell in the first MANT_BITS cells
   logic                 c_valid [N+1];
   logic [1:0]           c_kind  [N+1];
   logic                 c_neg   [N+1];
   logic signed [EW-1:0] c_ex    [N+1];
   logic [MANT_BITS-1:0] c_ma    [N+1];
   logic [MANT_BITS-1:0] c_mb    [N+1];
   logic [MANT_BITS:0]   c_rem   [N+1];
   logic [N-1:0]         c_acc   [N+1];
   logic [2:0]           c_flag  [N+1];

   assign c_valid[0] = s1_valid_ff;
   assign c_kind[0]  = s1_kind_ff;
   assign c_neg[0]   = s1_neg_ff;
   assign c_ex[0]    = s1_ex_ff;
   assign c_ma[0]    = s1_ma_ff;
   assign c_mb[0]    = s1_mb_ff;
   assign c_rem[0]   = '0;
   assign c_acc[0]   = N'(s1_sum_ff);
   assign c_flag[0]  = s1_flag_ff;

   for (genvar g = 0; g < N; g++) begin : g_cell
      fasmd_cell #(.MANT_BITS(MANT_BITS), .EXP_BITS(EXP_BITS), .STEP(g)) u_cell (
         .clock, .reset,
         .valid_in(c_valid[g]), .kind_in(c_kind[g]), .neg_in(c_neg[g]),
         .ex_in(c_ex[g]), .ma_in(c_ma[g]), .mb_in(c_mb[g]), .rem_in(c_rem[g]),
         .acc_in((g == 0 && (c_kind[0] == KIND_MUL || c_kind[0] == KIND_DIV))
                 ? '0 : c_acc[g]),
         .flag_in(c_flag[g]),
         .valid_out(c_valid[g+1]), .kind_out(c_kind[g+1]), .neg_out(c_neg[g+1]),
         .ex_out(c_ex[g+1]), .ma_out(c_ma[g+1]), .mb_out(c_mb[g+1]),
         .rem_out(c_rem[g+1]), .acc_out(c_acc[g+1]), .flag_out(c_flag[g+1])
      );
   end

   // final stage: normalize, range check, pack
   logic [1:0] f_kind;
   logic [N-1:0] f_acc;
   logic signed [EW-1:0] f_ex, e_out;
   logic [MANT_BITS-1:0] m_out, sub_m;
   logic [SW-1:0] sub_l;
   logic [1:0] st_c;
   logic [EXP_BITS+MANT_BITS:0] val_c;
   logic f_is_add;

   assign f_kind = c_kind[N];
   assign f_acc  = c_acc[N];
   assign f_ex   = c_ex[N];
   assign f_is_add = (f_kind == KIND_ADD || f_kind == KIND_SUB);
   assign sub_m  = f_acc[MANT_BITS-1:0];
   assign sub_l  = lzc(sub_m);

   always_comb begin
      priority if (f_is_add) begin
         if (f_acc[MANT_BITS]) begin
            m_out = f_acc[MANT_BITS:1]; e_out = f_ex + EW'(1);
         end else begin
            m_out = sub_m << sub_l; e_out = f_ex - EW'(sub_l);
         end
      end else if (f_kind == KIND_MUL) begin
         if (f_acc[N-1]) begin
            m_out = f_acc[N-1:MANT_BITS]; e_out = f_ex + EW'(1);
         end else begin
            m_out = f_acc[N-2:MANT_BITS-1]; e_out = f_ex;
         end
      end else begin
         if (f_acc[MANT_BITS]) begin
            m_out = f_acc[MANT_BITS:1]; e_out = f_ex;
         end else begin
            m_out = f_acc[MANT_BITS-1:0]; e_out = f_ex - EW'(1);
         end
      end
      st_c = ST_OK;
      val_c = '0;
      if (c_flag[N][1]) st_c = ST_DIVZERO;
      else if (c_flag[N][0] || m_out == '0) st_c = ST_OK;
      else if (e_out > EMax) st_c = ST_OVERFLOW;
      else if (e_out < 0) st_c = ST_UNDERFLOW;
      else val_c = {c_neg[N], e_out[EXP_BITS-1:0], m_out};
   end

   logic rsp_valid_ff;
   logic [EXP_BITS+MANT_BITS:0] rsp_value_ff;
   logic [1:0] rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= c_valid[N];
      rsp_value_ff  <= val_c;
      rsp_status_ff <= st_c;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
endmodule
`default_nettype wire
